@@ hdl/lsp_pkg.sv @@
package lsp_pkg;

  localparam int RANGE_W = 16;
  localparam int POS_W   = 13;
  localparam int IDX_W   = 3;

  localparam logic [POS_W-1:0]   MAX_SCAN_POINTS = POS_W'(4096);
  localparam logic [POS_W-1:0]   POS_MAX         = '1;

  localparam logic [RANGE_W-1:0] FAR_DEFAULT_RST = RANGE_W'(30000);
  localparam logic [RANGE_W-1:0] FRONT_LIMIT_RST = RANGE_W'(800);
  localparam logic [RANGE_W-1:0] SIDE_LIMIT_RST  = RANGE_W'(500);
  localparam logic [RANGE_W-1:0] REAR_LIMIT_RST  = RANGE_W'(500);

  // ceil(2^17 / 3): exact floor division by three for values below 2^17
  localparam logic [15:0] DIV3_RECIP = 16'd43691;
  localparam int          DIV3_SHIFT = 17;

  // angle in units of 30 degrees
  localparam logic [3:0] DEG_30  = 4'd1;
  localparam logic [3:0] DEG_90  = 4'd3;
  localparam logic [3:0] DEG_150 = 4'd5;
  localparam logic [3:0] DEG_210 = 4'd7;
  localparam logic [3:0] DEG_270 = 4'd9;
  localparam logic [3:0] DEG_330 = 4'd11;
  localparam logic [3:0] DEG_360 = 4'd12;

  typedef enum logic [IDX_W-1:0] {
    CFG_SCAN_POINTS = 3'd0,
    CFG_FAR_DEFAULT = 3'd1,
    CFG_FRONT_LIMIT = 3'd2,
    CFG_SIDE_LIMIT  = 3'd3,
    CFG_REAR_LIMIT  = 3'd4
  } cfg_reg_t;

  // sector edges as sample positions; the 0 degree edge is always 0
  typedef struct packed {
    logic [POS_W-1:0] b30;
    logic [POS_W-1:0] b90;
    logic [POS_W-1:0] b150;
    logic [POS_W-1:0] b210;
    logic [POS_W-1:0] b270;
    logic [POS_W-1:0] b330;
    logic [POS_W-1:0] b360;
  } bounds_t;

  localparam bounds_t BOUNDS_RST = '{
    b30:  POS_W'(30),  b90:  POS_W'(90),  b150: POS_W'(150),
    b210: POS_W'(210), b270: POS_W'(270), b330: POS_W'(330),
    b360: POS_W'(360)
  };

  // floor(n * k / 12) = floor(floor(n * k / 4) / 3)
  function automatic logic [POS_W-1:0] sector_bound(input logic [POS_W-1:0] n,
                                                     input logic [3:0] k);
    logic [POS_W+3:0] prod;
    logic [POS_W+1:0] quarter;
    logic [POS_W+17:0] scaled;
    prod    = n * k;
    quarter = prod[POS_W+3:2];
    scaled  = quarter * DIV3_RECIP;
    return scaled[DIV3_SHIFT+POS_W-1:DIV3_SHIFT];
  endfunction

endpackage

@@ hdl/lidar_sector_proximity.sv @@
// Channel  | Signals                                         | Direction
// ---------+-------------------------------------------------+----------
// in       | in_valid, in_stall, range_mm, last_sample        | sample in
// out      | out_valid, out_stall, front_mm .. collision_risk | result out
// cfg      | cfg_valid, cfg_ready, cfg_index, cfg_data        | write in
//
// One sample per cycle while in_stall is low. A sample is held in the input
// register; when it advances it updates its sector minimum, and a last sample
// loads the result register, which then offers the result to the output side.
// Reset (rst, synchronous) restores the register defaults, a 360 point scan,
// position 0 and minima of 30000. in_stall rises only when a last sample waits
// behind a result that the output side has not yet taken.
module lidar_sector_proximity (
  input  logic                         clk,
  input  logic                         rst,

  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic [lsp_pkg::RANGE_W-1:0]  range_mm,
  input  logic                         last_sample,

  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [lsp_pkg::RANGE_W-1:0]  front_mm,
  output logic [lsp_pkg::RANGE_W-1:0]  left_mm,
  output logic [lsp_pkg::RANGE_W-1:0]  right_mm,
  output logic [lsp_pkg::RANGE_W-1:0]  rear_mm,
  output logic                         collision_risk,

  input  logic                         cfg_valid,
  output logic                         cfg_ready,
  input  logic [lsp_pkg::IDX_W-1:0]    cfg_index,
  input  logic [lsp_pkg::RANGE_W-1:0]  cfg_data
);

  // configuration
  lsp_pkg::bounds_t              bounds;
  logic [lsp_pkg::RANGE_W-1:0]   far_default;
  logic [lsp_pkg::RANGE_W-1:0]   front_limit;
  logic [lsp_pkg::RANGE_W-1:0]   side_limit;
  logic [lsp_pkg::RANGE_W-1:0]   rear_limit;

  logic [lsp_pkg::POS_W-1:0]     cfg_points;
  lsp_pkg::bounds_t              bounds_next;

  // input register
  logic                          s1_valid;
  logic [lsp_pkg::RANGE_W-1:0]   s1_range;
  logic                          s1_last;
  logic                          s1_advance;
  logic                          in_accept;
  logic                          out_free;

  // scan state
  logic [lsp_pkg::POS_W-1:0]     pos;
  logic [lsp_pkg::RANGE_W-1:0]   front_min;
  logic [lsp_pkg::RANGE_W-1:0]   left_min;
  logic [lsp_pkg::RANGE_W-1:0]   right_min;
  logic [lsp_pkg::RANGE_W-1:0]   rear_min;
  logic [lsp_pkg::RANGE_W-1:0]   front_min_next;
  logic [lsp_pkg::RANGE_W-1:0]   left_min_next;
  logic [lsp_pkg::RANGE_W-1:0]   right_min_next;
  logic [lsp_pkg::RANGE_W-1:0]   rear_min_next;
  logic                          in_front;
  logic                          in_left;
  logic                          in_right;
  logic                          in_rear;
  logic                          risk_next;

  assign cfg_ready = 1'b1;

  // clamp the scan length and derive the sector edges at write time
  always_comb begin
    cfg_points = cfg_data[lsp_pkg::POS_W-1:0];
    if (cfg_points > lsp_pkg::MAX_SCAN_POINTS) begin
      cfg_points = lsp_pkg::MAX_SCAN_POINTS;
    end
    bounds_next.b30  = lsp_pkg::sector_bound(cfg_points, lsp_pkg::DEG_30);
    bounds_next.b90  = lsp_pkg::sector_bound(cfg_points, lsp_pkg::DEG_90);
    bounds_next.b150 = lsp_pkg::sector_bound(cfg_points, lsp_pkg::DEG_150);
    bounds_next.b210 = lsp_pkg::sector_bound(cfg_points, lsp_pkg::DEG_210);
    bounds_next.b270 = lsp_pkg::sector_bound(cfg_points, lsp_pkg::DEG_270);
    bounds_next.b330 = lsp_pkg::sector_bound(cfg_points, lsp_pkg::DEG_330);
    bounds_next.b360 = lsp_pkg::sector_bound(cfg_points, lsp_pkg::DEG_360);
  end

  // register writes; unknown indexes drop
  always_ff @(posedge clk) begin
    if (rst) begin
      bounds      <= lsp_pkg::BOUNDS_RST;
      far_default <= lsp_pkg::FAR_DEFAULT_RST;
      front_limit <= lsp_pkg::FRONT_LIMIT_RST;
      side_limit  <= lsp_pkg::SIDE_LIMIT_RST;
      rear_limit  <= lsp_pkg::REAR_LIMIT_RST;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        lsp_pkg::CFG_SCAN_POINTS: bounds      <= bounds_next;
        lsp_pkg::CFG_FAR_DEFAULT: far_default <= cfg_data;
        lsp_pkg::CFG_FRONT_LIMIT: front_limit <= cfg_data;
        lsp_pkg::CFG_SIDE_LIMIT:  side_limit  <= cfg_data;
        lsp_pkg::CFG_REAR_LIMIT:  rear_limit  <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake: a non-last sample always advances, a last one needs the result slot
  assign out_free   = !out_valid || !out_stall;
  assign s1_advance = s1_valid && (!s1_last || out_free);
  assign in_stall   = s1_valid && !s1_advance;
  assign in_accept  = in_valid && !in_stall;

  // hold the request in the input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_accept) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_accept) begin
      s1_range <= range_mm;
      s1_last  <= last_sample;
    end
  end

  // classify the position and lower the matching minimum
  always_comb begin
    in_front = (pos >= bounds.b150) && (pos < bounds.b210);
    in_left  = (pos >= bounds.b210) && (pos < bounds.b270);
    in_right = (pos >= bounds.b90)  && (pos < bounds.b150);
    in_rear  = (pos < bounds.b30) || ((pos >= bounds.b330) && (pos < bounds.b360));

    front_min_next = front_min;
    left_min_next  = left_min;
    right_min_next = right_min;
    rear_min_next  = rear_min;
    priority if (in_front) begin
      if (s1_range < front_min) front_min_next = s1_range;
    end else if (in_left) begin
      if (s1_range < left_min) left_min_next = s1_range;
    end else if (in_right) begin
      if (s1_range < right_min) right_min_next = s1_range;
    end else if (in_rear) begin
      if (s1_range < rear_min) rear_min_next = s1_range;
    end else begin
      // outside every sector: hold all minima
    end

    risk_next = (front_min_next < front_limit) || (left_min_next < side_limit) ||
                (right_min_next < side_limit) || (rear_min_next < rear_limit);
  end

  // advance the scan; restart from the far default after the last sample
  always_ff @(posedge clk) begin
    if (rst) begin
      pos       <= '0;
      front_min <= lsp_pkg::FAR_DEFAULT_RST;
      left_min  <= lsp_pkg::FAR_DEFAULT_RST;
      right_min <= lsp_pkg::FAR_DEFAULT_RST;
      rear_min  <= lsp_pkg::FAR_DEFAULT_RST;
    end else if (s1_advance) begin
      if (s1_last) begin
        pos       <= '0;
        front_min <= far_default;
        left_min  <= far_default;
        right_min <= far_default;
        rear_min  <= far_default;
      end else begin
        if (pos != lsp_pkg::POS_MAX) begin
          pos <= pos + 1'b1;
        end
        front_min <= front_min_next;
        left_min  <= left_min_next;
        right_min <= right_min_next;
        rear_min  <= rear_min_next;
      end
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance && s1_last) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance && s1_last) begin
      front_mm       <= front_min_next;
      left_mm        <= left_min_next;
      right_mm       <= right_min_next;
      rear_mm        <= rear_min_next;
      collision_risk <= risk_next;
    end
  end

`ifndef SYNTHESIS
  // a stall only ever comes from a last sample blocked by a pending result
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> (s1_valid && s1_last && out_valid && out_stall))
    else $error("input stalled without a blocked result");

  // the scan restarts at position zero after a last sample
  a_scan_restart: assert property (@(posedge clk) disable iff (rst)
    (s1_advance && s1_last) |=> (pos == '0))
    else $error("position not cleared after last sample");

  // a new result is only loaded when the previous one is gone
  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_stall) |-> !(s1_advance && s1_last))
    else $error("pending result overwritten");
`endif

endmodule
